// ===== rtl/swab_pkg.sv =====
// ----------------------------------------------------------------------------
// swab_pkg: shared definitions for the sliding window average buffer
// Request codes, field widths and reset defaults used by the interfaces
// and the RTL modules.
// ----------------------------------------------------------------------------
`default_nettype none

package swab_pkg;

   // field widths
   localparam int SAMPLE_W   = 32;
   localparam int REQ_TYPE_W = 3;
   localparam int CFG_W      = 5;

   // default number of sample slots
   localparam int MAX_DEPTH_DEFAULT = 16;

   // window length after reset
   localparam logic [CFG_W-1:0] WINDOW_LENGTH_RESET = 5'd16;

   // request codes
   localparam logic [REQ_TYPE_W-1:0] REQ_PUSH  = 3'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_AVG   = 3'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_CLEAR = 3'd2;
   localparam logic [REQ_TYPE_W-1:0] REQ_SIZE  = 3'd3;
   localparam logic [REQ_TYPE_W-1:0] REQ_LAST  = 3'd4;

   // response status codes
   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_IGNORED = 1'b1;

endpackage : swab_pkg

`default_nettype wire

// ===== rtl/swab_ifs.sv =====
// ----------------------------------------------------------------------------
// swab_ifs: channel interfaces of the sliding window average buffer
// Request, response and configuration channels, each with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface swab_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [swab_pkg::REQ_TYPE_W-1:0]      req_type;
   logic signed [swab_pkg::SAMPLE_W-1:0] sample_value;

   modport source (output valid, output req_type, output sample_value, input ready);
   modport sink   (input valid, input req_type, input sample_value, output ready);
endinterface : swab_req_if

interface swab_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 status;
   logic signed [swab_pkg::SAMPLE_W-1:0] result_value;

   modport source (output valid, output status, output result_value, input ready);
   modport sink   (input valid, input status, input result_value, output ready);
endinterface : swab_rsp_if

interface swab_csr_if;
   logic                       valid;
   logic                       ready;
   logic [swab_pkg::CFG_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface : swab_csr_if

`default_nettype wire

// ===== rtl/swab_window_mem.sv =====
// ----------------------------------------------------------------------------
// swab_window_mem: sample storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module swab_window_mem #(
   parameter int DEPTH  = swab_pkg::MAX_DEPTH_DEFAULT,
   parameter int ADDR_W = 4,
   parameter int DATA_W = swab_pkg::SAMPLE_W
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [0:DEPTH-1];
   logic [DATA_W-1:0] rd_data_ff;

   // write one sample
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read one sample, registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule : swab_window_mem

`default_nettype wire

// ===== rtl/swab_divider.sv =====
// ----------------------------------------------------------------------------
// swab_divider: serial signed-by-unsigned divider
// Restoring division, one quotient bit per cycle; quotient truncates
// toward zero. The divisor must be nonzero.
// ----------------------------------------------------------------------------
`default_nettype none

module swab_divider #(
   parameter int SUM_W = 37,
   parameter int DIV_W = 5
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic signed [SUM_W-1:0] dividend,
   input  wire logic        [DIV_W-1:0] divisor,
   output logic                         done,
   output logic             [SUM_W-1:0] quotient
);

   localparam int CNT_W = $clog2(SUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [SUM_W-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0] den_ff, den_in;
   logic             neg_ff, neg_in;

   logic [DIV_W:0]   shifted;
   logic [DIV_W:0]   diff;
   logic             take;

   // trial subtract of the divisor from the shifted remainder
   assign shifted = {rem_ff, quo_ff[SUM_W-1]};
   assign diff    = shifted - {1'b0, den_ff};
   assign take    = (shifted >= {1'b0, den_ff});

   // step the division
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(SUM_W);
         rem_in  = '0;
         quo_in  = dividend[SUM_W-1] ? ('0 - $unsigned(dividend)) : $unsigned(dividend);
         den_in  = divisor;
         neg_in  = dividend[SUM_W-1];
      end else if (busy_ff) begin
         rem_in = take ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
         quo_in = {quo_ff[SUM_W-2:0], take};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   // restore the sign
   assign done     = done_ff;
   assign quotient = neg_ff ? ('0 - quo_ff) : quo_ff;

endmodule : swab_divider

`default_nettype wire

// ===== rtl/sliding_window_average_buffer.sv =====
// ----------------------------------------------------------------------------
// sliding_window_average_buffer: moving average over a window of samples
// Circular sample store with push, average, clear, size and last requests.
//
//   channel   dir   fields                   moves
//   req_bus   in    req_type, sample_value   one request item
//   rsp_bus   out   status, result_value     one response item per request
//   csr_bus   in    data                     window_length write
//
// Push, clear, size and unknown requests go from idle to the done state;
// last passes through a read state first. Average makes one memory read per
// sample through the single read port, then one quotient bit per cycle in
// the serial divider. Reset is synchronous, clears the fill count and sets
// the window length back to 16; the sample store needs no clearing. A
// stalled response holds in the output register while the next request is
// taken.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_average_buffer #(
   parameter int MAX_DEPTH = swab_pkg::MAX_DEPTH_DEFAULT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   swab_req_if.sink   req_bus,
   swab_rsp_if.source rsp_bus,
   swab_csr_if.sink   csr_bus
);

   import swab_pkg::*;

   localparam int AW    = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int FW    = $clog2(MAX_DEPTH + 1);
   localparam int PW    = AW + 2;
   localparam int SUM_W = SAMPLE_W + FW;

   // sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SUM  = 3'd1;
   localparam logic [2:0] S_DIV  = 3'd2;
   localparam logic [2:0] S_LAST = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   // wrap a slot index that is below twice the depth
   function automatic logic [AW-1:0] wrap_addr(input logic [PW-1:0] v);
      logic [PW-1:0] r;
      r = (v >= PW'(MAX_DEPTH)) ? (v - PW'(MAX_DEPTH)) : v;
      return r[AW-1:0];
   endfunction

   logic [2:0]                 state_ff, state_in;
   logic [CFG_W-1:0]           wlen_ff;
   logic [AW-1:0]              head_ff, head_in;
   logic [FW-1:0]              fill_ff, fill_in;
   logic [FW-1:0]              issue_ff, issue_in;
   logic [AW-1:0]              rd_ptr_ff, rd_ptr_in;
   logic                       rd_valid_ff, rd_valid_in;
   logic signed [SUM_W-1:0]    acc_ff, acc_in;
   logic                       res_status_ff, res_status_in;
   logic [SAMPLE_W-1:0]        res_value_ff, res_value_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_status_ff;
   logic [SAMPLE_W-1:0]        rsp_value_ff;

   logic                       req_fire;
   logic                       rsp_free;
   logic [FW-1:0]              len;
   logic [FW-1:0]              drop;
   logic                       wr_en;
   logic [AW-1:0]              wr_addr;
   logic                       rd_en;
   logic [AW-1:0]              rd_addr;
   logic [SAMPLE_W-1:0]        rd_data;
   logic                       div_start;
   logic                       div_done;
   logic [SUM_W-1:0]           quotient;

   // take nothing while reset is held
   assign req_bus.ready = (state_ff == S_IDLE) && !reset;
   assign csr_bus.ready = !reset;
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign rsp_free      = !rsp_valid_ff || rsp_bus.ready;

   // clamp the window length to 1..MAX_DEPTH
   always_comb begin
      if (wlen_ff == '0) begin
         len = FW'(1);
      end else if (32'(wlen_ff) > 32'(MAX_DEPTH)) begin
         len = FW'(MAX_DEPTH);
      end else begin
         len = FW'(wlen_ff);
      end
   end

   assign drop = fill_ff - len + FW'(1);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      fill_in       = fill_ff;
      issue_in      = issue_ff;
      rd_ptr_in     = rd_ptr_ff;
      acc_in        = acc_ff;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;
      wr_en         = 1'b0;
      wr_addr       = wrap_addr(PW'(head_ff) + PW'(fill_ff));
      rd_en         = 1'b0;
      rd_addr       = rd_ptr_ff;
      div_start     = 1'b0;
      rd_valid_in   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               res_status_in = STATUS_OK;
               res_value_in  = '0;
               state_in      = S_DONE;
               unique case (req_bus.req_type)
                  REQ_PUSH: begin
                     wr_en = 1'b1;
                     if (fill_ff < len) begin
                        fill_in = fill_ff + FW'(1);
                     end else begin
                        head_in = wrap_addr(PW'(head_ff) + PW'(drop));
                        fill_in = len;
                     end
                  end
                  REQ_AVG: begin
                     if (fill_ff == '0) begin
                        res_status_in = STATUS_IGNORED;
                     end else begin
                        acc_in    = '0;
                        issue_in  = '0;
                        rd_ptr_in = head_ff;
                        state_in  = S_SUM;
                     end
                  end
                  REQ_CLEAR: begin
                     fill_in = '0;
                  end
                  REQ_SIZE: begin
                     res_value_in = SAMPLE_W'(fill_ff);
                  end
                  REQ_LAST: begin
                     if (fill_ff == '0) begin
                        res_status_in = STATUS_IGNORED;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = wrap_addr(PW'(head_ff) + PW'(fill_ff) - PW'(1));
                        state_in = S_LAST;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SUM: begin
            // issue one read per cycle, add each sample as it returns
            if (issue_ff != fill_ff) begin
               rd_en       = 1'b1;
               rd_addr     = rd_ptr_ff;
               rd_ptr_in   = wrap_addr(PW'(rd_ptr_ff) + PW'(1));
               issue_in    = issue_ff + FW'(1);
               rd_valid_in = 1'b1;
            end
            if (rd_valid_ff) begin
               acc_in = acc_ff + SUM_W'(signed'(rd_data));
            end
            if ((issue_ff == fill_ff) && !rd_valid_ff) begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               res_value_in = quotient[SAMPLE_W-1:0];
               state_in     = S_DONE;
            end
         end
         S_LAST: begin
            res_value_in = rd_data;
            state_in     = S_DONE;
         end
         S_DONE: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // hand the result to the output register once it is free
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if ((state_ff == S_DONE) && rsp_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wlen_ff      <= WINDOW_LENGTH_RESET;
         head_ff      <= '0;
         fill_ff      <= '0;
         issue_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         issue_ff     <= issue_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_bus.valid && csr_bus.ready) begin
            wlen_ff <= csr_bus.data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rd_ptr_ff     <= rd_ptr_in;
      acc_ff        <= acc_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      if ((state_ff == S_DONE) && rsp_free) begin
         rsp_status_ff <= res_status_ff;
         rsp_value_ff  <= res_value_ff;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.status       = rsp_status_ff;
   assign rsp_bus.result_value = rsp_value_ff;

   swab_window_mem #(
      .DEPTH  (MAX_DEPTH),
      .ADDR_W (AW),
      .DATA_W (SAMPLE_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_bus.sample_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   swab_divider #(
      .SUM_W (SUM_W),
      .DIV_W (FW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (acc_ff),
      .divisor  (fill_ff),
      .done     (div_done),
      .quotient (quotient)
   );

endmodule : sliding_window_average_buffer

`default_nettype wire

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: sliding window average buffer
// Drives push, average, clear, size, last and reserved requests through the
// request channel. Every accepted item is run through a local copy of the
// window, and each response is checked against the oldest outstanding
// answer. Window length is rewritten between phases, covering zero, the
// maximum depth and values above it. Both channel sides idle at random, and
// one phase holds the response side off long enough to back up the input.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import swab_pkg::*;

   localparam int DEPTH           = MAX_DEPTH_DEFAULT;
   localparam int MAX_WAIT        = 14;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int DRAIN_CYCLES    = 64;
   localparam int PHASE_ITEMS     = 140;

   // request codes the block does not define
   localparam logic [REQ_TYPE_W-1:0] REQ_RSVD_LO  = 3'd5;
   localparam logic [REQ_TYPE_W-1:0] REQ_RSVD_MID = 3'd6;
   localparam logic [REQ_TYPE_W-1:0] REQ_RSVD_HI  = 3'd7;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

   typedef enum int {WAIT_NONE, WAIT_ANY, WAIT_SPARSE} wait_mode_type;

   typedef struct {
      logic [REQ_TYPE_W-1:0]      kind;
      logic signed [SAMPLE_W-1:0] sample;
   } window_request_type;

   typedef struct {
      logic [REQ_TYPE_W-1:0]      kind;
      logic                       status;
      logic signed [SAMPLE_W-1:0] value;
   } window_answer_type;

   logic clock;
   logic reset;

   swab_req_if req_bus ();
   swab_rsp_if rsp_bus ();
   swab_csr_if csr_bus ();

   sliding_window_average_buffer DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   window_request_type pending_requests[$];
   window_answer_type  window_answers[$];

   // local copy of the window
   logic signed [SAMPLE_W-1:0] window_store [DEPTH];
   int unsigned                window_fill   = 0;
   logic [CFG_W-1:0]           window_length = WINDOW_LENGTH_RESET;

   int            mismatch_count = 0;
   int            queued_count   = 0;
   int            accepted_count = 0;
   int            req_wait       = 0;
   int            rsp_wait       = 0;
   wait_mode_type req_wait_mode  = WAIT_NONE;
   wait_mode_type rsp_wait_mode  = WAIT_NONE;
   logic          req_taken      = 1'b0;
   bit            rsp_blocked    = 1'b0;
   bit            hold_off_go    = 1'b0;

   // 100 MHz clock
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic int draw_wait(wait_mode_type mode);
      case (mode)
         WAIT_NONE: return 0;
         WAIT_ANY:  return $urandom_range(0, MAX_WAIT);
         default:   return ($urandom_range(0, 3) == 0) ? $urandom_range(1, MAX_WAIT) : 0;
      endcase
   endfunction

   // Apply one request to the window copy and return the answer it should get
   function automatic window_answer_type apply_window_request(window_request_type item);
      window_answer_type answer;
      int unsigned       span;
      int unsigned       drop;
      longint            total;
      answer.kind   = item.kind;
      answer.status = STATUS_OK;
      answer.value  = '0;
      span = (window_length == 0) ? 1 : (window_length > DEPTH) ? DEPTH : window_length;
      case (item.kind)
         REQ_PUSH: begin
            if (window_fill < span) begin
               window_store[window_fill] = item.sample;
               window_fill++;
            end else begin
               // keep the newest span-1 samples, then append the new one
               drop = window_fill - span + 1;
               for (int i = 0; i + 1 < span; i++)
                  window_store[i] = window_store[i + drop];
               window_store[span - 1] = item.sample;
               window_fill = span;
            end
         end
         REQ_AVG: begin
            if (window_fill == 0) begin
               answer.status = STATUS_IGNORED;
            end else begin
               total = 0;
               for (int i = 0; i < window_fill; i++)
                  total += longint'(window_store[i]);
               total = total / longint'(window_fill);
               answer.value = total[SAMPLE_W-1:0];
            end
         end
         REQ_CLEAR: window_fill = 0;
         REQ_SIZE:  answer.value = window_fill;
         REQ_LAST: begin
            if (window_fill == 0)
               answer.status = STATUS_IGNORED;
            else
               answer.value = window_store[window_fill - 1];
         end
         default: ;
      endcase
      return answer;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] random_sample();
      case ($urandom_range(0, 9))
         0:       return SAMPLE_MAX;
         1:       return SAMPLE_MIN;
         2:       return $urandom_range(0, 1) ? '0 : '1;
         3, 4, 5: return int'($urandom_range(0, 2000)) - 1000;
         default: return $urandom;
      endcase
   endfunction

   // Mostly pushes and queries; a few clears and reserved codes as noise
   function automatic window_request_type random_request();
      window_request_type item;
      int                 pick;
      pick = $urandom_range(0, 99);
      if (pick < 50)
         item.kind = REQ_PUSH;
      else if (pick < 68)
         item.kind = REQ_AVG;
      else if (pick < 80)
         item.kind = REQ_LAST;
      else if (pick < 88)
         item.kind = REQ_SIZE;
      else if (pick < 91)
         item.kind = REQ_CLEAR;
      else if (pick < 94)
         item.kind = REQ_RSVD_LO;
      else if (pick < 97)
         item.kind = REQ_RSVD_MID;
      else
         item.kind = REQ_RSVD_HI;
      item.sample = random_sample();
      return item;
   endfunction

   task automatic queue_request(logic [REQ_TYPE_W-1:0] kind, logic signed [SAMPLE_W-1:0] sample);
      window_request_type item;
      item.kind   = kind;
      item.sample = sample;
      pending_requests.push_back(item);
      queued_count++;
   endtask

   // Hold until every queued item is accepted and answered
   task automatic wait_idle();
      while (!(accepted_count == queued_count && window_answers.size() == 0))
         @(negedge clock);
   endtask

   task automatic write_window_length(logic [CFG_W-1:0] length);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= length;
      do
         @(posedge clock);
      while (!(csr_bus.valid === 1'b1 && csr_bus.ready === 1'b1));
      window_length = length;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // Drive request items from the pending queue with a drawn gap before each
   always @(negedge clock) begin
      window_request_type item;
      if (req_taken || !req_bus.valid) begin
         if (req_wait > 0) begin
            req_bus.valid <= 1'b0;
            req_wait--;
         end else if (pending_requests.size() > 0) begin
            item = pending_requests.pop_front();
            req_bus.valid        <= 1'b1;
            req_bus.req_type     <= item.kind;
            req_bus.sample_value <= item.sample;
            req_wait = draw_wait(req_wait_mode);
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Take accepted items into the window copy
   always @(posedge clock) begin
      window_request_type item;
      req_taken <= req_bus.valid && req_bus.ready;
      if (req_bus.valid && req_bus.ready) begin
         item.kind   = req_bus.req_type;
         item.sample = req_bus.sample_value;
         window_answers.push_back(apply_window_request(item));
         accepted_count++;
      end
   end

   // Stall the response side per item, or for the whole hold-off
   always @(negedge clock) begin
      if (rsp_blocked) begin
         rsp_bus.ready <= 1'b0;
      end else if (rsp_wait > 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_wait--;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Check each response against the oldest outstanding answer
   always @(posedge clock) begin
      window_answer_type want;
      if (rsp_bus.valid && rsp_bus.ready) begin
         rsp_wait = draw_wait(rsp_wait_mode);
         if (window_answers.size() == 0) begin
            $display("%0t: response with none outstanding: status %0b value %0d",
                     $time, rsp_bus.status, rsp_bus.result_value);
            mismatch_count++;
         end else begin
            want = window_answers.pop_front();
            if (rsp_bus.status !== want.status) begin
               $display("%0t: request %0d status expected %0b got %0b",
                        $time, want.kind, want.status, rsp_bus.status);
               mismatch_count++;
            end
            if (rsp_bus.result_value !== want.value) begin
               $display("%0t: request %0d result_value expected %0d got %0d",
                        $time, want.kind, want.value, rsp_bus.result_value);
               mismatch_count++;
            end
         end
      end
   end

   // Long response hold-off while the sender keeps offering items
   initial begin
      wait (hold_off_go);
      rsp_blocked = 1'b1;
      repeat (HOLD_OFF_CYCLES) @(posedge clock);
      rsp_blocked = 1'b0;
   end

   initial begin
      #10_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      logic [CFG_W-1:0] phase_lengths[$];
      phase_lengths = '{5'd31, 5'd16, 5'd1, 5'd3, 5'd17, 5'd8, 5'd2, 5'd5, 5'd12, 5'd0, 5'd15};
      phase_lengths.push_back($urandom_range(0, 31));

      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.req_type     = REQ_PUSH;
      req_bus.sample_value = '0;
      rsp_bus.ready        = 1'b0;
      csr_bus.valid        = 1'b0;
      csr_bus.data         = WINDOW_LENGTH_RESET;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty window, reserved codes, overflowing sums at reset length
      req_wait_mode = WAIT_ANY;
      rsp_wait_mode = WAIT_ANY;
      queue_request(REQ_AVG, SAMPLE_MAX);
      queue_request(REQ_LAST, SAMPLE_MIN);
      queue_request(REQ_SIZE, '0);
      queue_request(REQ_RSVD_LO, '1);
      queue_request(REQ_RSVD_MID, '0);
      queue_request(REQ_RSVD_HI, '1);
      queue_request(REQ_CLEAR, '0);
      repeat (3) queue_request(REQ_PUSH, SAMPLE_MAX);
      queue_request(REQ_AVG, '0);
      repeat (4) queue_request(REQ_PUSH, SAMPLE_MIN);
      queue_request(REQ_AVG, '0);
      queue_request(REQ_LAST, '0);
      wait_idle();

      // length zero acts as one; lowering below fill shows on the next push
      write_window_length('0);
      queue_request(REQ_SIZE, '0);
      queue_request(REQ_AVG, '0);
      queue_request(REQ_PUSH, -32'sd9);
      queue_request(REQ_SIZE, '0);
      queue_request(REQ_LAST, '0);
      queue_request(REQ_AVG, '0);

      // random phases over a spread of window lengths
      foreach (phase_lengths[p]) begin
         wait_idle();
         write_window_length(phase_lengths[p]);
         if (p == 0) begin
            req_wait_mode = WAIT_NONE;
            rsp_wait_mode = WAIT_NONE;
         end else if (p == 1) begin
            req_wait_mode = WAIT_ANY;
            rsp_wait_mode = WAIT_ANY;
         end else if (p == 4) begin
            req_wait_mode = WAIT_NONE;
            rsp_wait_mode = WAIT_SPARSE;
         end else begin
            req_wait_mode = wait_mode_type'($urandom_range(0, 2));
            rsp_wait_mode = wait_mode_type'($urandom_range(0, 2));
         end
         repeat (PHASE_ITEMS) begin
            window_request_type item;
            item = random_request();
            queue_request(item.kind, item.sample);
         end
         if (p == 4)
            hold_off_go = 1'b1;
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && window_answers.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule : testbench

`default_nettype wire
